FILE: hw/rtl/hhd_pkg.sv
package hhd_pkg;

  // Control tick length and the fixed-point constants that follow from it.
  localparam int TICK_MS      = 10;
  localparam int Q_FRAC       = 24;
  localparam int GYRO_GAIN    = (TICK_MS * 128849 + 50) / 100;
  localparam int GYRO_GAIN_W  = 18;
  localparam int GYRO_SHIFT   = 8;
  localparam int RAMP_STEP    = 167772;
  localparam int DRIVE_LIM    = 2047;

  // Field and state widths.
  localparam int SPEED_W      = 11;
  localparam int RUNTIME_W    = 16;
  localparam int MAXDRV_W     = 10;
  localparam int GYRO_W       = 16;
  localparam int DRIVE_W      = 12;
  localparam int Q_W          = 32;
  localparam int RAMP_W       = 26;
  localparam int CORR_W       = 26;
  localparam int ELAPSED_W    = 17;
  localparam int GPROD_W      = GYRO_W + GYRO_GAIN_W;
  localparam int BASE_W       = SPEED_W + RAMP_W + 1;
  localparam int STEER_W      = MAXDRV_W + 1 + CORR_W;
  localparam int SUM_W        = 40;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;

  localparam int MAX_DRIVE_RESET = 255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_TIME_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE   = 2'd2;

  // Item kinds carried in the input tuser bit.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_IDLE_TICK,
    ST_MUL_GYRO,
    ST_INTEG,
    ST_CORR,
    ST_MUL_DRIVE,
    ST_FINISH
  } hhd_state_t;

  typedef struct packed {
    logic load;
    logic start_run;
    logic idle_tick;
    logic mul_gyro;
    logic integ;
    logic corr;
    logic mul_drive;
    logic finish;
    logic emit;
  } hhd_cmd_t;

  typedef struct packed {
    logic is_start;
    logic running;
    logic out_busy;
  } hhd_status_t;

endpackage

FILE: hw/rtl/hhd_ctrl.sv
module hhd_ctrl import hhd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hhd_status_t status,
  output hhd_cmd_t    cmd
);

  hhd_state_t state;
  hhd_state_t state_next;
  logic       pending;
  logic       pending_next;

  // The result waits for the output register in the idle state while the pending flag is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    state_next   = state;
    pending_next = pending;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (pending) begin
          if (!status.out_busy) begin
            cmd.emit     = 1'b1;
            pending_next = 1'b0;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load = 1'b1;
            if (status.is_start) begin
              state_next = ST_START;
            end else if (!status.running) begin
              state_next = ST_IDLE_TICK;
            end else begin
              state_next = ST_MUL_GYRO;
            end
          end
        end
      end
      ST_START: begin
        cmd.start_run = 1'b1;
        pending_next  = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_IDLE_TICK: begin
        cmd.idle_tick = 1'b1;
        pending_next  = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_MUL_GYRO: begin
        cmd.mul_gyro = 1'b1;
        state_next   = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr   = 1'b1;
        state_next = ST_MUL_DRIVE;
      end
      ST_MUL_DRIVE: begin
        cmd.mul_drive = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish   = 1'b1;
        pending_next = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/hhd_datapath.sv
module hhd_datapath import hhd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_mode,
  input  logic signed [GYRO_W-1:0] in_gyro,
  input  logic                  in_keep,
  input  hhd_cmd_t              cmd,
  output hhd_status_t           status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [DRIVE_W-1:0] out_left,
  output logic signed [DRIVE_W-1:0] out_right,
  output logic                  out_done
);

  localparam logic signed [Q_W:0] Q_MAX = (Q_W+1)'((64'sd1 <<< (Q_W-1)) - 1);
  localparam logic signed [Q_W:0] Q_MIN = -(Q_W+1)'(64'sd1 <<< (Q_W-1));
  localparam logic signed [CORR_W-1:0] CORR_ONE = CORR_W'(64'sd1 <<< Q_FRAC);
  localparam logic signed [SUM_W-1:0] TRUNC_ADD = SUM_W'((64'sd1 <<< Q_FRAC) - 1);
  localparam logic signed [SUM_W-Q_FRAC-1:0] LIM_HI = (SUM_W-Q_FRAC)'(DRIVE_LIM);
  localparam logic signed [SUM_W-Q_FRAC-1:0] LIM_LO = -(SUM_W-Q_FRAC)'(DRIVE_LIM);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  logic signed [SPEED_W-1:0]  drive_speed;
  logic [RUNTIME_W-1:0]       run_time_ms;
  logic [MAXDRV_W-1:0]        max_drive;

  logic signed [Q_W-1:0]      yaw_angle;
  logic signed [Q_W-1:0]      previous_error;
  logic [RAMP_W-1:0]          speed_ramp;
  logic [ELAPSED_W-1:0]       elapsed_ms;
  logic                       running;

  logic signed [GYRO_W-1:0]   gyro_q;
  logic                       keep_q;
  logic signed [GPROD_W-1:0]  gyro_prod;
  logic signed [Q_W-1:0]      err_q;
  logic signed [CORR_W-1:0]   corr_q;
  logic signed [BASE_W-1:0]   base_q;
  logic signed [STEER_W-1:0]  steer_q;

  logic signed [DRIVE_W-1:0]  res_left;
  logic signed [DRIVE_W-1:0]  res_right;
  logic                       res_done;

  // Yaw integration and error.
  logic signed [GPROD_W-1:0]  yaw_inc;
  logic signed [GPROD_W:0]    yaw_sum;
  logic signed [Q_W:0]        yaw_sat;
  logic signed [Q_W:0]        err_neg;
  logic signed [Q_W:0]        err_sat;

  // PD correction.
  logic signed [Q_W+1:0]      corr_sum;
  logic signed [CORR_W-1:0]   corr_sat;

  // Drive sums.
  logic signed [SUM_W-1:0]    steer_signed;
  logic signed [SUM_W-1:0]    sum_l;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-Q_FRAC-1:0] quo_l;
  logic signed [SUM_W-Q_FRAC-1:0] quo_r;
  logic [ELAPSED_W:0]         elapsed_add;
  logic [ELAPSED_W-1:0]       elapsed_new;
  logic                       run_ends;

  function automatic logic signed [SUM_W-Q_FRAC-1:0] trunc_q(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] adj;
    adj = v[SUM_W-1] ? v + TRUNC_ADD : v;
    return adj[SUM_W-1:Q_FRAC];
  endfunction

  function automatic logic signed [DRIVE_W-1:0] sat_drive(
    input logic signed [SUM_W-Q_FRAC-1:0] v
  );
    logic signed [SUM_W-Q_FRAC-1:0] c;
    c = v;
    if (v > LIM_HI) begin
      c = LIM_HI;
    end else if (v < LIM_LO) begin
      c = LIM_LO;
    end
    return c[DRIVE_W-1:0];
  endfunction

  always_comb begin
    yaw_inc = gyro_prod >>> GYRO_SHIFT;
    yaw_sum = (GPROD_W+1)'(yaw_angle) + (GPROD_W+1)'(yaw_inc);
    if (yaw_sum > (GPROD_W+1)'(Q_MAX)) begin
      yaw_sat = Q_MAX;
    end else if (yaw_sum < (GPROD_W+1)'(Q_MIN)) begin
      yaw_sat = Q_MIN;
    end else begin
      yaw_sat = yaw_sum[Q_W:0];
    end
    err_neg = -yaw_sat;
    err_sat = (err_neg > Q_MAX) ? Q_MAX : err_neg;

    corr_sum = (Q_W+2)'(err_q >>> 1) + (Q_W+2)'(err_q) - (Q_W+2)'(previous_error);
    if (corr_sum > (Q_W+2)'(CORR_ONE)) begin
      corr_sat = CORR_ONE;
    end else if (corr_sum < -(Q_W+2)'(CORR_ONE)) begin
      corr_sat = -CORR_ONE;
    end else begin
      corr_sat = corr_sum[CORR_W-1:0];
    end

    // Steering changes sign with the direction of travel.
    steer_signed = (drive_speed > 0) ? SUM_W'(steer_q) : -SUM_W'(steer_q);
    sum_l = SUM_W'(base_q) + steer_signed;
    sum_r = SUM_W'(base_q) - steer_signed;
    quo_l = trunc_q(sum_l);
    quo_r = trunc_q(sum_r);

    elapsed_add = {1'b0, elapsed_ms} + (ELAPSED_W+1)'(TICK_MS);
    elapsed_new = elapsed_add[ELAPSED_W] ? ELAPSED_MAX : elapsed_add[ELAPSED_W-1:0];
    run_ends = (elapsed_new >= ELAPSED_W'(run_time_ms)) || !keep_q;
  end

  // Configuration registers and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed    <= '0;
      run_time_ms    <= '0;
      max_drive      <= MAXDRV_W'(MAX_DRIVE_RESET);
      yaw_angle      <= '0;
      previous_error <= '0;
      speed_ramp     <= '0;
      elapsed_ms     <= '0;
      running        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DRIVE_SPEED: drive_speed <= cfg_data[SPEED_W-1:0];
          REG_RUN_TIME_MS: run_time_ms <= cfg_data[RUNTIME_W-1:0];
          REG_MAX_DRIVE:   max_drive   <= cfg_data[MAXDRV_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start_run) begin
        yaw_angle      <= '0;
        previous_error <= '0;
        speed_ramp     <= '0;
        elapsed_ms     <= '0;
        running        <= 1'b1;
      end
      if (cmd.integ) begin
        yaw_angle <= yaw_sat[Q_W-1:0];
      end
      if (cmd.corr) begin
        previous_error <= err_q;
        if (speed_ramp < RAMP_W'(64'sd1 <<< Q_FRAC)) begin
          speed_ramp <= speed_ramp + RAMP_W'(RAMP_STEP);
        end
      end
      if (cmd.finish) begin
        elapsed_ms <= elapsed_new;
        if (run_ends) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Working registers along the tick path.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro_q <= in_gyro;
      keep_q <= in_keep;
    end
    if (cmd.mul_gyro) begin
      gyro_prod <= GPROD_W'(gyro_q) * GPROD_W'(signed'(GYRO_GAIN_W'(GYRO_GAIN)));
    end
    if (cmd.integ) begin
      err_q <= err_sat[Q_W-1:0];
    end
    if (cmd.corr) begin
      corr_q <= corr_sat;
    end
    if (cmd.mul_drive) begin
      base_q  <= BASE_W'(drive_speed) * BASE_W'(signed'({1'b0, speed_ramp}));
      steer_q <= STEER_W'(signed'({1'b0, max_drive})) * STEER_W'(corr_q);
    end
    if (cmd.start_run) begin
      res_left  <= '0;
      res_right <= '0;
      res_done  <= 1'b0;
    end
    if (cmd.idle_tick) begin
      res_left  <= '0;
      res_right <= '0;
      res_done  <= 1'b1;
    end
    if (cmd.finish) begin
      res_left  <= run_ends ? '0 : sat_drive(quo_l);
      res_right <= run_ends ? '0 : sat_drive(quo_r);
      res_done  <= run_ends;
    end
  end

  // Output register: holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_left  <= res_left;
      out_right <= res_right;
      out_done  <= res_done;
    end
  end

  always_comb begin
    status.is_start = (in_mode == MODE_START);
    status.running  = running;
    status.out_busy = out_valid && !out_ready;
  end

endmodule

FILE: hw/rtl/heading_hold_drive_controller.sv
// A start item takes the start step to its result, and a tick while no run is active takes
// the idle-tick step; a tick during a run takes the full step chain of the sequencer below.
// One item is in the block at a time: the next item is taken only once the last result
// has left the sequencer's step chain for the output register.
// A finished result waits in the output register, and the next item is taken while it waits.
// Synchronous reset clears the run state, the registers to their reset values and the output.
module heading_hold_drive_controller import hhd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Bits 15:0 gyro_rate, bit 16 keep_going, bits 23:17 zero.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Bit 0 mode.
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Bits 11:0 left_drive, bits 23:12 right_drive.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // done_res: the run is over and the drives are zero.
  output logic                  m_axis_tlast
);

  hhd_cmd_t    cmd;
  hhd_status_t status;

  logic signed [DRIVE_W-1:0] out_left;
  logic signed [DRIVE_W-1:0] out_right;

  // The sequencer walks a tick through gyro scaling, yaw integration, the PD
  // correction with the speed ramp, the two drive products and the final
  // sums, one register stage per step. Start items and ticks outside a run
  // take a short path to a fixed result; a start item also opens a new run.
  hhd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the run state and the output register.
  hhd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (s_axis_tuser),
    .in_gyro   (s_axis_tdata[GYRO_W-1:0]),
    .in_keep   (s_axis_tdata[GYRO_W]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_left  (out_left),
    .out_right (out_right),
    .out_done  (m_axis_tlast)
  );

  // The two drives fill the output word exactly, with no padding.
  assign m_axis_tdata = {out_right, out_left};

endmodule

FILE: hw/rtl/hhd_checker.sv
module hhd_checker import hhd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // Reset leaves no result on the output.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A result that ends a run carries zero drives.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
    else $error("non-zero drive with done");

  // Drives never reach the most negative code.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[DRIVE_W-1:0] != {1'b1, {(DRIVE_W-1){1'b0}}}
      && m_axis_tdata[2*DRIVE_W-1:DRIVE_W] != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive outside saturation range");

  // One item at a time: the input is closed in the cycle after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule

bind heading_hold_drive_controller hhd_checker u_hhd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
